>>> hdl/ledspi_pkg.sv
// Shared types and constants for the addressable LED SPI encoder.
// Used by every module of the block; depends on nothing else.
package ledspi_pkg;

   localparam int BITS_PER_PIXEL = 24;
   localparam int BIT_CNT_W      = 5;
   localparam int MAX_TAIL       = 40;
   localparam int TAIL_W         = 6;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = 2;
   localparam int QCNT_W         = 3;
   localparam int CSR_INDEX_W    = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_CODE  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_CODE = 8'd1;

   localparam logic [7:0] ONE_CODE_RESET  = 8'd248;
   localparam logic [7:0] ZERO_CODE_RESET = 8'd192;
   localparam logic [7:0] TAIL_BYTE       = 8'h00;

   typedef struct packed {
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] blue;
      logic       frame_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       last;
   } rsp_item_type;

   // One classified pixel as it waits between the front and the back.
   typedef struct packed {
      logic [BITS_PER_PIXEL-1:0] pixel_bits;
      logic [TAIL_W-1:0]         tail_len;
   } pixel_desc_type;

   typedef struct packed {
      logic [7:0] one_code;
      logic [7:0] zero_code;
   } code_pair_type;

endpackage

>>> hdl/addressable_led_spi_encoder.sv
// Top level of the addressable LED SPI encoder: front, queue, back and the code registers.
// Depends on ledspi_pkg, ledspi_front, ledspi_queue and ledspi_back.
//
// Each pixel word pushed in (green, red, blue and a frame end flag) comes out as
// 24 SPI words, green first and most significant bit first, where a one bit
// becomes the one_code pattern and a zero bit the zero_code pattern. A pixel
// with frame_end set is followed by RESET_BYTES zero words (at most 40) that
// form the latch gap, and the final word of each pixel carries last. The back
// serializer sends one word per clock while rsp_pop stays high; a pixel fills
// 24 words, or 24 + RESET_BYTES when it ends a frame, and pixels follow each
// other without gaps. A pushed pixel waits in the front register and the queue
// before the back takes it. A one-stage front plus a four-deep queue absorb
// pushes while the back is busy, so req_full rises only when that buffering is
// used up. Configuration writes are always taken (csr_ready is tied high);
// index 0 sets one_code, index 1 sets zero_code, and other indices are ignored.
// Change the codes only while the block holds no pixels.
module addressable_led_spi_encoder #(
   parameter int RESET_BYTES = 40
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  ledspi_pkg::req_item_type              req_item,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output ledspi_pkg::rsp_item_type              rsp_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ledspi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                            csr_data
);
   import ledspi_pkg::*;

   logic           q_push, q_full, q_pop, q_empty;
   pixel_desc_type q_wr_data, q_rd_data;
   code_pair_type  codes;
   logic [7:0]     one_code_ff, one_code_in;
   logic [7:0]     zero_code_ff, zero_code_in;
   logic           csr_write;

   // The code registers have no side effects, so writes never need to wait.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      one_code_in  = one_code_ff;
      zero_code_in = zero_code_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ONE_CODE: begin
               one_code_in = csr_data;
            end
            CSR_ZERO_CODE: begin
               zero_code_in = csr_data;
            end
            default: begin
               one_code_in = one_code_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_code_ff  <= ONE_CODE_RESET;
         zero_code_ff <= ZERO_CODE_RESET;
      end else begin
         one_code_ff  <= one_code_in;
         zero_code_ff <= zero_code_in;
      end
   end

   assign codes.one_code  = one_code_ff;
   assign codes.zero_code = zero_code_ff;

   ledspi_front #(
      .RESET_BYTES (RESET_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_data   (q_wr_data)
   );

   ledspi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_data (q_wr_data),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_rd_data)
   );

   ledspi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_rd_data),
      .codes     (codes),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

>>> hdl/ledspi_front.sv
// Front stage: accepts pixel words, packs them in GRB order and works out the tail length.
// Depends on ledspi_pkg.
module ledspi_front #(
   parameter int RESET_BYTES = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  ledspi_pkg::req_item_type  req_item,
   output logic                      q_push,
   input  logic                      q_full,
   output ledspi_pkg::pixel_desc_type q_data
);
   import ledspi_pkg::*;

   localparam int TAIL_CLAMPED = (RESET_BYTES > MAX_TAIL) ? MAX_TAIL : RESET_BYTES;
   localparam logic [TAIL_W-1:0] TAIL_LEN = TAIL_W'(TAIL_CLAMPED);

   logic           valid_ff, valid_in;
   pixel_desc_type desc_ff, desc_in;
   logic           accept;

   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = valid_ff && !q_full;
   assign q_data   = desc_ff;

   always_comb begin
      desc_in.pixel_bits = {req_item.green, req_item.red, req_item.blue};
      desc_in.tail_len   = req_item.frame_end ? TAIL_LEN : '0;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         desc_ff <= desc_in;
      end
   end

endmodule

>>> hdl/ledspi_queue.sv
// Short queue of classified pixels between the front and the back.
// Depends on ledspi_pkg.
module ledspi_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  ledspi_pkg::pixel_desc_type push_data,
   input  logic                       pop,
   output logic                       empty,
   output ledspi_pkg::pixel_desc_type pop_data
);
   import ledspi_pkg::*;

   pixel_desc_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/ledspi_back.sv
// Back stage: serializes one pixel into 24 pattern bytes plus an optional zero tail.
// Depends on ledspi_pkg.
module ledspi_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   output logic                       q_pop,
   input  ledspi_pkg::pixel_desc_type q_data,
   input  ledspi_pkg::code_pair_type  codes,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output ledspi_pkg::rsp_item_type   rsp_item
);
   import ledspi_pkg::*;

   logic [BITS_PER_PIXEL-1:0] shift_ff, shift_in;
   logic [BIT_CNT_W-1:0]      bits_left_ff, bits_left_in;
   logic [TAIL_W-1:0]         tail_left_ff, tail_left_in;
   logic                      out_valid_ff, out_valid_in;
   rsp_item_type              out_item_ff, out_item_in;
   logic                      advance, busy, in_bits, emit, emit_last, load;

   assign advance   = !out_valid_ff || rsp_pop;
   assign busy      = (bits_left_ff != '0) || (tail_left_ff != '0);
   assign in_bits   = (bits_left_ff != '0);
   assign emit      = advance && busy;
   assign emit_last = in_bits ? ((bits_left_ff == BIT_CNT_W'(1)) && (tail_left_ff == '0))
                              : (tail_left_ff == TAIL_W'(1));
   // The next pixel is taken in the cycle that sends the current one's final word.
   assign load      = !q_empty && (!busy || (emit && emit_last));
   assign q_pop     = load;

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      shift_in     = shift_ff;
      bits_left_in = bits_left_ff;
      tail_left_in = tail_left_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (emit) begin
         if (in_bits) begin
            shift_in     = {shift_ff[BITS_PER_PIXEL-2:0], 1'b0};
            bits_left_in = bits_left_ff - 1'b1;
         end else begin
            tail_left_in = tail_left_ff - 1'b1;
         end
      end
      if (load) begin
         shift_in     = q_data.pixel_bits;
         bits_left_in = BIT_CNT_W'(BITS_PER_PIXEL);
         tail_left_in = q_data.tail_len;
      end
      if (advance) begin
         out_valid_in = emit;
         if (in_bits) begin
            out_item_in.spi_byte = shift_ff[BITS_PER_PIXEL-1] ? codes.one_code
                                                               : codes.zero_code;
         end else begin
            out_item_in.spi_byte = TAIL_BYTE;
         end
         out_item_in.last = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_left_ff <= '0;
         tail_left_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         bits_left_ff <= bits_left_in;
         tail_left_ff <= tail_left_in;
         out_valid_ff <= out_valid_in;
      end
      shift_ff    <= shift_in;
      out_item_ff <= out_item_in;
   end

endmodule

>>> hdl/ledspi_checker.sv
// Port-level checks for the addressable LED SPI encoder, bound to its top level.
// Depends on ledspi_pkg and addressable_led_spi_encoder.
module ledspi_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_push,
   input logic                               req_full,
   input ledspi_pkg::req_item_type           req_item,
   input logic                               rsp_empty,
   input logic                               rsp_pop,
   input ledspi_pkg::rsp_item_type           rsp_item,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic [ledspi_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [7:0]                         csr_data
);
   import ledspi_pkg::*;

   // Reset leaves no result word behind.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // Reset leaves room for a new pixel.
   a_not_full_after_reset: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input reported full after reset");

   // The code registers take every write.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration write was refused");

   // A waiting result word stays put until it is popped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)))
      else $error("result word changed before it was popped");

endmodule

bind addressable_led_spi_encoder ledspi_checker u_checker (.*);
